// ----- rtl/core/intel_hex_record_encoder_unit_assert.svh -----
// Assertion macros used by the encoder back part.
// Each macro expects clk and arst_n to be visible in the scope where it is used.
`ifndef INTEL_HEX_RECORD_ENCODER_UNIT_ASSERT_SVH
`define INTEL_HEX_RECORD_ENCODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IHEX_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ihex encoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IHEX_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ihex encoder: next-cycle check failed");

`endif

// ----- rtl/core/ihex_enc_pkg.sv -----
`default_nettype none
package ihex_enc_pkg;

	// Largest number of data bytes in one record.
	localparam int RECORD_BYTES = 16;
	localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
	localparam int CNT_W = $clog2(RECORD_BYTES + 1);
	localparam int ADDR_W = 16;

	// Depth of the command queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Input operation codes.
	typedef enum logic [1:0] {
		OP_DATA   = 2'd0,
		OP_FINISH = 2'd1,
		OP_CANCEL = 2'd2,
		OP_UNUSED = 2'd3
	} opcode_t;

	// Record types and fixed characters.
	localparam logic [7:0] REC_TYPE_DATA = 8'h00;
	localparam logic [7:0] REC_TYPE_EOF  = 8'h01;
	localparam logic [7:0] CHAR_COLON    = 8'h3A;
	localparam logic [7:0] CHAR_CR       = 8'h0D;
	localparam logic [7:0] CHAR_LF       = 8'h0A;

	// One command per input transaction that causes any work in the back part.
	typedef struct packed {
		logic              store;
		logic [IDX_W-1:0]  idx;
		logic [7:0]        wr_byte;
		logic              rec;
		logic [CNT_W-1:0]  len;
		logic [ADDR_W-1:0] addr;
		logic              eof;
	} cmd_t;

	// Character sequencer states of the back part.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COLON,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_AH_HI,
		ST_AH_LO,
		ST_AL_HI,
		ST_AL_LO,
		ST_TYPE_HI,
		ST_TYPE_LO,
		ST_DATA_HI,
		ST_DATA_LO,
		ST_SUM_HI,
		ST_SUM_LO,
		ST_CR,
		ST_LF
	} state_t;

	// Uppercase ASCII hex digit for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'h0, nib};
		end else begin
			c = 8'h37 + {4'h0, nib};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ihex_enc_in_if.sv -----
`default_nettype none
interface ihex_enc_in_if;
	import ihex_enc_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;

	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink (input valid, input opcode, input data_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ihex_enc_out_if.sv -----
`default_nettype none
interface ihex_enc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_of_run;

	modport source (output valid, output out_char, output last_of_run, input ready);
	modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ihex_enc_front.sv -----
`default_nettype none
module ihex_enc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	ihex_enc_in_if.sink         items,
	output ihex_enc_pkg::cmd_t  cmd,
	output logic                push,
	input  wire logic           full
);
	import ihex_enc_pkg::*;

	logic [CNT_W-1:0]  fill_q;
	logic [ADDR_W-1:0] addr_q;
	logic              accept;
	logic              full_rec;
	opcode_t           op;

	assign items.ready = !full;
	assign accept      = items.valid && items.ready;
	assign op          = opcode_t'(items.opcode);
	assign full_rec    = (fill_q == CNT_W'(RECORD_BYTES - 1));

	// Classify the transaction into a command for the back part.
	always_comb begin
		cmd         = '0;
		push        = 1'b0;
		cmd.idx     = fill_q[IDX_W-1:0];
		cmd.wr_byte = items.data_byte;
		cmd.addr    = addr_q;
		case (op)
			OP_DATA: begin
				push      = accept;
				cmd.store = 1'b1;
				cmd.rec   = full_rec;
				cmd.len   = CNT_W'(RECORD_BYTES);
			end
			OP_FINISH: begin
				push    = accept;
				cmd.rec = (fill_q != '0);
				cmd.len = fill_q;
				cmd.eof = 1'b1;
			end
			OP_CANCEL: begin
				push    = accept && (fill_q != '0);
				cmd.rec = 1'b1;
				cmd.len = fill_q;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Fill count and address of the record being gathered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			addr_q <= '0;
		end else if (accept) begin
			case (op)
				OP_DATA: begin
					if (full_rec) begin
						fill_q <= '0;
						addr_q <= addr_q + ADDR_W'(RECORD_BYTES);
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				OP_FINISH, OP_CANCEL: begin
					fill_q <= '0;
					addr_q <= '0;
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/ihex_enc_cmd_queue.sv -----
`default_nettype none
module ihex_enc_cmd_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ihex_enc_pkg::cmd_t  wr_cmd,
	input  wire logic                push,
	output logic                     full,
	output ihex_enc_pkg::cmd_t       rd_cmd,
	output logic                     not_empty,
	input  wire logic                pop
);
	import ihex_enc_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_cmd    = slot_q[rd_ptr_q];

	// Command storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/ihex_enc_back.sv -----
`default_nettype none
`include "intel_hex_record_encoder_unit_assert.svh"
module ihex_enc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ihex_enc_pkg::cmd_t  cmd,
	input  wire logic                cmd_valid,
	output logic                     pop,
	ihex_enc_out_if.source           chars
);
	import ihex_enc_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic [7:0]        buf_q [RECORD_BYTES];
	logic [CNT_W-1:0]  rec_len_q;
	logic [ADDR_W-1:0] rec_addr_q;
	logic              rec_eof_q;
	logic              pend_eof_q;
	logic [IDX_W-1:0]  k_q;
	logic [7:0]        sum_q;
	logic              out_valid_q;
	logic [7:0]        out_char_q;
	logic              out_last_q;

	logic              adv;
	logic              emit;
	logic [7:0]        char_d;
	logic              last_d;
	logic              load_cmd;
	logic              load_eof;
	logic              add_sum;
	logic [7:0]        add_val;
	logic              k_inc;
	logic [7:0]        len_byte;
	logic [7:0]        type_byte;
	logic [7:0]        cur_byte;
	logic [7:0]        cksum;

	assign chars.valid       = out_valid_q;
	assign chars.out_char    = out_char_q;
	assign chars.last_of_run = out_last_q;

	// The output register can take a new character when empty or being drained.
	assign adv       = !out_valid_q || chars.ready;
	assign len_byte  = 8'(rec_len_q);
	assign type_byte = rec_eof_q ? REC_TYPE_EOF : REC_TYPE_DATA;
	assign cur_byte  = buf_q[k_q];
	assign cksum     = 8'h00 - sum_q;

	// Next state and the character produced in each state.
	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		char_d   = CHAR_COLON;
		last_d   = 1'b0;
		pop      = 1'b0;
		load_cmd = 1'b0;
		load_eof = 1'b0;
		add_sum  = 1'b0;
		add_val  = '0;
		k_inc    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					pop = 1'b1;
					if (cmd.rec) begin
						load_cmd = 1'b1;
						state_d  = ST_COLON;
					end else if (cmd.eof) begin
						load_eof = 1'b1;
						state_d  = ST_COLON;
					end
				end
			end
			ST_COLON: begin
				emit    = adv;
				char_d  = CHAR_COLON;
				state_d = adv ? ST_LEN_HI : state_q;
			end
			ST_LEN_HI: begin
				emit    = adv;
				char_d  = hex_char(len_byte[7:4]);
				state_d = adv ? ST_LEN_LO : state_q;
			end
			ST_LEN_LO: begin
				emit    = adv;
				char_d  = hex_char(len_byte[3:0]);
				add_sum = adv;
				add_val = len_byte;
				state_d = adv ? ST_AH_HI : state_q;
			end
			ST_AH_HI: begin
				emit    = adv;
				char_d  = hex_char(rec_addr_q[15:12]);
				state_d = adv ? ST_AH_LO : state_q;
			end
			ST_AH_LO: begin
				emit    = adv;
				char_d  = hex_char(rec_addr_q[11:8]);
				add_sum = adv;
				add_val = rec_addr_q[15:8];
				state_d = adv ? ST_AL_HI : state_q;
			end
			ST_AL_HI: begin
				emit    = adv;
				char_d  = hex_char(rec_addr_q[7:4]);
				state_d = adv ? ST_AL_LO : state_q;
			end
			ST_AL_LO: begin
				emit    = adv;
				char_d  = hex_char(rec_addr_q[3:0]);
				add_sum = adv;
				add_val = rec_addr_q[7:0];
				state_d = adv ? ST_TYPE_HI : state_q;
			end
			ST_TYPE_HI: begin
				emit    = adv;
				char_d  = hex_char(type_byte[7:4]);
				state_d = adv ? ST_TYPE_LO : state_q;
			end
			ST_TYPE_LO: begin
				emit    = adv;
				char_d  = hex_char(type_byte[3:0]);
				add_sum = adv;
				add_val = type_byte;
				if (adv) begin
					state_d = (rec_len_q == '0) ? ST_SUM_HI : ST_DATA_HI;
				end
			end
			ST_DATA_HI: begin
				emit    = adv;
				char_d  = hex_char(cur_byte[7:4]);
				state_d = adv ? ST_DATA_LO : state_q;
			end
			ST_DATA_LO: begin
				emit    = adv;
				char_d  = hex_char(cur_byte[3:0]);
				add_sum = adv;
				add_val = cur_byte;
				k_inc   = adv;
				if (adv) begin
					if ((CNT_W'(k_q) + 1'b1) == rec_len_q) begin
						state_d = ST_SUM_HI;
					end else begin
						state_d = ST_DATA_HI;
					end
				end
			end
			ST_SUM_HI: begin
				emit    = adv;
				char_d  = hex_char(cksum[7:4]);
				state_d = adv ? ST_SUM_LO : state_q;
			end
			ST_SUM_LO: begin
				emit    = adv;
				char_d  = hex_char(cksum[3:0]);
				state_d = adv ? ST_CR : state_q;
			end
			ST_CR: begin
				emit    = adv;
				char_d  = CHAR_CR;
				state_d = adv ? ST_LF : state_q;
			end
			ST_LF: begin
				emit   = adv;
				char_d = CHAR_LF;
				last_d = !pend_eof_q;
				if (adv) begin
					if (pend_eof_q) begin
						load_eof = 1'b1;
						state_d  = ST_COLON;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register, output valid and last flags, and the EOF flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			pend_eof_q  <= 1'b0;
			rec_eof_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
				out_last_q  <= last_d;
			end else if (chars.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_cmd) begin
				rec_eof_q  <= 1'b0;
				pend_eof_q <= cmd.eof;
			end else if (load_eof) begin
				rec_eof_q  <= 1'b1;
				pend_eof_q <= 1'b0;
			end
		end
	end

	// Output character and record payload: buffer, length, address, byte index and running sum.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= char_d;
		end
		if (pop && cmd.store) begin
			buf_q[cmd.idx] <= cmd.wr_byte;
		end
		if (load_cmd) begin
			rec_len_q  <= cmd.len;
			rec_addr_q <= cmd.addr;
		end else if (load_eof) begin
			rec_len_q  <= '0;
			rec_addr_q <= '0;
		end
		if (load_cmd || load_eof) begin
			k_q   <= '0;
			sum_q <= '0;
		end else begin
			if (k_inc) begin
				k_q <= k_q + 1'b1;
			end
			if (add_sum) begin
				sum_q <= sum_q + add_val;
			end
		end
	end

	`IHEX_ASSERT_IMPLY(a_data_index_in_range,
		(state_q == ST_DATA_HI || state_q == ST_DATA_LO), (CNT_W'(k_q) < rec_len_q))
	`IHEX_ASSERT_IMPLY(a_eof_not_chained, pend_eof_q && state_q != ST_IDLE, !rec_eof_q)
	`IHEX_ASSERT_IMPLY(a_last_only_on_lf, out_valid_q && out_last_q, out_char_q == CHAR_LF)
	`IHEX_ASSERT_NEXT(a_eof_follows_data,
		state_q == ST_LF && adv && pend_eof_q, state_q == ST_COLON && rec_eof_q)

endmodule
`default_nettype wire

// ----- rtl/core/intel_hex_record_encoder_unit.sv -----
`default_nettype none
// Channel  Dir  Payload                     Meaning
// items    in   opcode[1:0], data_byte[7:0] data byte, finish or cancel
// chars    out  out_char[7:0], last_of_run  one character of HEX record text
//
// A data byte that does not complete a record is only written into the back part's buffer.
// A full 16-byte record is 45 characters at one per cycle while chars is ready,
// set by the character sequencer and its single output register; the EOF record
// with its line end is 13 characters.
// Reset clears the fill count, the record address, the queue and the sequencer.
// A stall on chars holds the sequencer; items keeps being taken until the
// four-entry command queue is full.
module intel_hex_record_encoder_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ihex_enc_in_if.sink    items,
	ihex_enc_out_if.source chars
);
	import ihex_enc_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic push;
	logic full;
	logic not_empty;
	logic pop;

	ihex_enc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.cmd    (front_cmd),
		.push   (push),
		.full   (full)
	);

	ihex_enc_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_cmd    (front_cmd),
		.push      (push),
		.full      (full),
		.rd_cmd    (head_cmd),
		.not_empty (not_empty),
		.pop       (pop)
	);

	ihex_enc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_valid (not_empty),
		.pop       (pop),
		.chars     (chars)
	);

endmodule
`default_nettype wire
